// ===== design/amkd_pkg.sv =====
// Shared types, codes and the letter table of the adaptive morse key decoder.
`default_nettype none

package amkd_pkg;

	// Key event kinds
	typedef enum logic [1:0] {
		CMD_PRESS   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CANCEL  = 2'd2,
		CMD_POLL    = 2'd3
	} cmd_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_LETTER = 2'd0,
		KIND_SPACE  = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_UNIT_AT_RESET = 2'd0;
	localparam logic [1:0] CFG_UNIT_FLOOR    = 2'd1;
	localparam logic [1:0] CFG_UNIT_CEILING  = 2'd2;

	// Register reset values in milliseconds
	localparam logic [9:0] UNIT_AT_RESET_DEFAULT = 10'd120;
	localparam logic [9:0] UNIT_FLOOR_DEFAULT    = 10'd60;
	localparam logic [9:0] UNIT_CEILING_DEFAULT  = 10'd600;

	// Dots in a row that mean "delete last word"
	localparam logic [3:0] ERROR_DOT_COUNT = 4'd8;

	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_NONE  = 7'h00;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] char_code;
		logic       last_of_run;
	} result_t;

	// Look up a letter from its symbol count and bits (newest in bit 0, dash = 1).
	function automatic logic [6:0] morse_char(input logic [3:0] count, input logic [7:0] bits);
		logic [5:0] mask;
		logic [4:0] pattern;
		logic [6:0] ch;
		mask = (6'd1 << count[2:0]) - 6'd1;
		pattern = bits[4:0] & mask[4:0];
		if (count == 4'd0 || count > 4'd5) begin
			ch = CHAR_NONE;
		end else begin
			case ({count[2:0], pattern})
				{3'd2, 5'd1}:  ch = 7'h41; // A
				{3'd4, 5'd8}:  ch = 7'h42; // B
				{3'd4, 5'd10}: ch = 7'h43; // C
				{3'd3, 5'd4}:  ch = 7'h44; // D
				{3'd1, 5'd0}:  ch = 7'h45; // E
				{3'd4, 5'd2}:  ch = 7'h46; // F
				{3'd3, 5'd6}:  ch = 7'h47; // G
				{3'd4, 5'd0}:  ch = 7'h48; // H
				{3'd2, 5'd0}:  ch = 7'h49; // I
				{3'd4, 5'd7}:  ch = 7'h4A; // J
				{3'd3, 5'd5}:  ch = 7'h4B; // K
				{3'd4, 5'd4}:  ch = 7'h4C; // L
				{3'd2, 5'd3}:  ch = 7'h4D; // M
				{3'd2, 5'd2}:  ch = 7'h4E; // N
				{3'd3, 5'd7}:  ch = 7'h4F; // O
				{3'd4, 5'd6}:  ch = 7'h50; // P
				{3'd4, 5'd13}: ch = 7'h51; // Q
				{3'd3, 5'd2}:  ch = 7'h52; // R
				{3'd3, 5'd0}:  ch = 7'h53; // S
				{3'd1, 5'd1}:  ch = 7'h54; // T
				{3'd3, 5'd1}:  ch = 7'h55; // U
				{3'd4, 5'd1}:  ch = 7'h56; // V
				{3'd3, 5'd3}:  ch = 7'h57; // W
				{3'd4, 5'd9}:  ch = 7'h58; // X
				{3'd4, 5'd11}: ch = 7'h59; // Y
				{3'd4, 5'd12}: ch = 7'h5A; // Z
				{3'd5, 5'd31}: ch = 7'h30; // 0
				{3'd5, 5'd15}: ch = 7'h31; // 1
				{3'd5, 5'd7}:  ch = 7'h32; // 2
				{3'd5, 5'd3}:  ch = 7'h33; // 3
				{3'd5, 5'd1}:  ch = 7'h34; // 4
				{3'd5, 5'd0}:  ch = 7'h35; // 5
				{3'd5, 5'd16}: ch = 7'h36; // 6
				{3'd5, 5'd24}: ch = 7'h37; // 7
				{3'd5, 5'd28}: ch = 7'h38; // 8
				{3'd5, 5'd30}: ch = 7'h39; // 9
				default:       ch = CHAR_NONE;
			endcase
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== design/adaptive_morse_key_decoder.sv =====
// Top level of the adaptive morse key decoder: event register, decode logic, result queue.
//
// Usage:
//   Item channel (item_valid / item_stall, cmd, time_ms) takes one timestamped key
//   event per request. An event lands in an input register and is decoded there
//   once the queue has room, pushing zero, one or two results into a four-entry
//   result queue. The result channel (result_valid / result_stall, kind,
//   char_code, last_of_run) presents the queue head; last_of_run marks the last
//   result of one event.
//   Throughput: one event per cycle, limited only by the result queue
//   draining one result per cycle; item_stall rises while the queue holds more
//   than two results and the input register is occupied.
//   Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; a write to register 0 also reloads the running unit estimate.
//   Reset (arst_n low) empties the queue and input register, clears the letter
//   and key state and loads the register defaults. A stalled receiver only
//   fills the queue, and the input side then holds its request.
`default_nettype none

module adaptive_morse_key_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] time_ms,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [6:0]  char_code,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	// Dash divide-by-three: saturation point and reciprocal (2^22 / 3, rounded up)
	localparam logic [37:0] DivSat   = 38'd786432;
	localparam logic [19:0] DivSatN  = 20'd786432;
	localparam logic [20:0] RecipDiv = 21'd1398102;
	localparam logic [37:0] ObsSat   = 38'd262144;
	localparam logic [18:0] ObsSatN  = 19'd262144;

	// Input register
	logic                valid_s1;
	amkd_pkg::cmd_t      cmd_s1;
	logic [31:0]         time_s1;

	// Configuration registers
	logic [9:0]  unit_reset_q;
	logic [9:0]  unit_floor_q;
	logic [9:0]  unit_ceiling_q;

	// Decoder state
	logic        key_down_q;
	logic [31:0] press_start_q;
	logic [31:0] last_release_q;
	logic        letter_pending_q;
	logic [7:0]  sym_bits_q;
	logic [3:0]  sym_cnt_q;
	logic [15:0] unit_q;
	logic        space_allowed_q;
	logic        dash_seen_q;

	// Next state
	logic        key_down_d;
	logic [31:0] press_start_d;
	logic [31:0] last_release_d;
	logic        letter_pending_d;
	logic [7:0]  sym_bits_d;
	logic [3:0]  sym_cnt_d;
	logic [15:0] unit_d;
	logic        space_allowed_d;
	logic        dash_seen_d;

	// Result queue
	amkd_pkg::result_t res_mem_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  cnt_q;

	logic        proc;
	logic        pop;
	logic [1:0]  push_n;
	amkd_pkg::result_t res0;
	amkd_pkg::result_t res1;

	// Datapath
	logic [31:0] dur;
	logic [37:0] dur_q6;
	logic [37:0] dur_p1;
	logic        dash;
	logic [19:0] div_in;
	logic [40:0] div_prod;
	logic [18:0] obs_dash;
	logic [18:0] obs_dot;
	logic [18:0] obs;
	logic [17:0] unit3;
	logic [18:0] unit7;
	logic [19:0] upd_sum;
	logic [17:0] upd;
	logic [17:0] upd_hi;
	logic [17:0] lim_hi;
	logic [17:0] lim_lo;
	logic [17:0] upd_clamp;
	logic [31:0] sil;
	logic [37:0] sil_q6;
	logic        letter_gap;
	logic        word_gap;
	logic [3:0]  cnt_inc;
	logic        dash_any;
	logic [6:0]  letter_ch;
	logic        has_letter;
	logic        has_space;
	logic        has_delete;

	// Handshakes
	assign proc         = valid_s1 && (cnt_q <= 3'd2);
	assign item_stall   = valid_s1 && !(cnt_q <= 3'd2);
	assign pop          = result_valid && !result_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = (cnt_q != 3'd0);
	assign kind         = res_mem_q[rd_ptr_q].kind;
	assign char_code    = res_mem_q[rd_ptr_q].char_code;
	assign last_of_run  = res_mem_q[rd_ptr_q].last_of_run;

	// Hold the event in the input register until it is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1  <= amkd_pkg::cmd_t'(cmd);
			time_s1 <= time_ms;
		end
	end

	// Press timing, dash test, estimate update, gap tests and letter lookup
	always_comb begin
		dur      = time_s1 - press_start_q;
		dur_q6   = {dur, 6'd0};
		dur_p1   = dur_q6 + 38'd1;
		dash     = dur_q6 >= {21'd0, unit_q, 1'b0};
		// Beyond the saturation point the update clamps to the ceiling anyway
		div_in   = (dur_p1 >= DivSat) ? DivSatN : dur_p1[19:0];
		div_prod = div_in * RecipDiv;
		obs_dash = div_prod[40:22];
		obs_dot  = (dur_q6 >= ObsSat) ? ObsSatN : dur_q6[18:0];
		obs      = dash ? obs_dash : obs_dot;
		unit3    = {2'd0, unit_q} + {1'b0, unit_q, 1'b0};
		unit7    = {unit_q, 3'd0} - {3'd0, unit_q};
		upd_sum  = {2'd0, unit3} + {1'b0, obs} + 20'd2;
		upd      = upd_sum[19:2];
		lim_hi   = {2'd0, unit_ceiling_q, 6'd0};
		lim_lo   = {2'd0, unit_floor_q, 6'd0};
		upd_hi   = (upd > lim_hi) ? lim_hi : upd;
		upd_clamp = (upd_hi < lim_lo) ? lim_lo : upd_hi;
		sil      = time_s1 - last_release_q;
		sil_q6   = {sil, 6'd0};
		letter_gap = sil_q6 >= {20'd0, unit3};
		word_gap   = sil_q6 >= {19'd0, unit7};
		cnt_inc  = (sym_cnt_q == 4'd15) ? sym_cnt_q : sym_cnt_q + 4'd1;
		dash_any = dash_seen_q || dash;
		letter_ch = amkd_pkg::morse_char(sym_cnt_q, sym_bits_q);
	end

	// Next state and results for the event in the input register
	always_comb begin
		key_down_d       = key_down_q;
		press_start_d    = press_start_q;
		last_release_d   = last_release_q;
		letter_pending_d = letter_pending_q;
		sym_bits_d       = sym_bits_q;
		sym_cnt_d        = sym_cnt_q;
		unit_d           = unit_q;
		space_allowed_d  = space_allowed_q;
		dash_seen_d      = dash_seen_q;
		has_letter       = 1'b0;
		has_space        = 1'b0;
		has_delete       = 1'b0;
		case (cmd_s1)
			amkd_pkg::CMD_PRESS: begin
				key_down_d    = 1'b1;
				press_start_d = time_s1;
			end
			amkd_pkg::CMD_CANCEL: begin
				key_down_d = 1'b0;
			end
			amkd_pkg::CMD_RELEASE: begin
				if (key_down_q) begin
					key_down_d       = 1'b0;
					sym_bits_d       = {sym_bits_q[6:0], dash};
					sym_cnt_d        = cnt_inc;
					dash_seen_d      = dash_any;
					letter_pending_d = 1'b1;
					last_release_d   = time_s1;
					unit_d           = upd_clamp[15:0];
					// A long run of dots erases the last word
					if (cnt_inc >= amkd_pkg::ERROR_DOT_COUNT && !dash_any) begin
						sym_bits_d       = 8'd0;
						sym_cnt_d        = 4'd0;
						dash_seen_d      = 1'b0;
						letter_pending_d = 1'b0;
						space_allowed_d  = 1'b0;
						has_delete       = 1'b1;
					end
				end
			end
			amkd_pkg::CMD_POLL: begin
				if (!key_down_q && letter_pending_q && letter_gap) begin
					sym_bits_d       = 8'd0;
					sym_cnt_d        = 4'd0;
					dash_seen_d      = 1'b0;
					letter_pending_d = 1'b0;
					has_letter       = (letter_ch != amkd_pkg::CHAR_NONE);
					has_space        = word_gap && (has_letter || space_allowed_q);
					if (has_letter) begin
						space_allowed_d = 1'b1;
					end
					if (has_space) begin
						space_allowed_d = 1'b0;
					end
				end
			end
			default: begin
				key_down_d = key_down_q;
			end
		endcase
	end

	// Pack results in order, marking the last one
	always_comb begin
		res1.kind        = amkd_pkg::KIND_SPACE;
		res1.char_code   = amkd_pkg::CHAR_SPACE;
		res1.last_of_run = 1'b1;
		if (has_delete) begin
			res0.kind        = amkd_pkg::KIND_DELETE;
			res0.char_code   = amkd_pkg::CHAR_NONE;
			res0.last_of_run = 1'b1;
		end else if (has_letter) begin
			res0.kind        = amkd_pkg::KIND_LETTER;
			res0.char_code   = letter_ch;
			res0.last_of_run = !has_space;
		end else begin
			res0 = res1;
		end
		push_n = {1'b0, has_delete || has_letter || has_space} +
			{1'b0, has_letter && has_space};
	end

	// Advance decoder state; a write to register 0 reloads the estimate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q       <= 1'b0;
			press_start_q    <= 32'd0;
			last_release_q   <= 32'd0;
			letter_pending_q <= 1'b0;
			sym_bits_q       <= 8'd0;
			sym_cnt_q        <= 4'd0;
			unit_q           <= {amkd_pkg::UNIT_AT_RESET_DEFAULT, 6'd0};
			space_allowed_q  <= 1'b0;
			dash_seen_q      <= 1'b0;
			unit_reset_q     <= amkd_pkg::UNIT_AT_RESET_DEFAULT;
			unit_floor_q     <= amkd_pkg::UNIT_FLOOR_DEFAULT;
			unit_ceiling_q   <= amkd_pkg::UNIT_CEILING_DEFAULT;
		end else begin
			if (proc) begin
				key_down_q       <= key_down_d;
				press_start_q    <= press_start_d;
				last_release_q   <= last_release_d;
				letter_pending_q <= letter_pending_d;
				sym_bits_q       <= sym_bits_d;
				sym_cnt_q        <= sym_cnt_d;
				unit_q           <= unit_d;
				space_allowed_q  <= space_allowed_d;
				dash_seen_q      <= dash_seen_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					amkd_pkg::CFG_UNIT_AT_RESET: begin
						unit_reset_q <= cfg_data;
						unit_q       <= {cfg_data, 6'd0};
					end
					amkd_pkg::CFG_UNIT_FLOOR:   unit_floor_q   <= cfg_data;
					amkd_pkg::CFG_UNIT_CEILING: unit_ceiling_q <= cfg_data;
					default:                    unit_reset_q   <= unit_reset_q;
				endcase
			end
		end
	end

	// Result queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + push_n;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (proc ? {1'b0, push_n} : 3'd0) - {2'd0, pop};
		end
	end

	// Write up to two results a cycle
	always_ff @(posedge clk) begin
		if (proc && push_n != 2'd0) begin
			res_mem_q[wr_ptr_q] <= res0;
		end
		if (proc && push_n == 2'd2) begin
			res_mem_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	// Queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("result queue overfilled");

	// A stalled event keeps its register contents
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_stall) |=> (valid_s1 && $stable(time_s1)))
		else $error("stalled event lost");

	// Delete and space results always close the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (kind == amkd_pkg::KIND_DELETE || kind == amkd_pkg::KIND_SPACE))
		|-> last_of_run)
		else $error("delete or space not last of run");

	// A pending letter holds at least one symbol
	assert property (@(posedge clk) disable iff (!arst_n)
		letter_pending_q |-> (sym_cnt_q != 4'd0))
		else $error("pending letter with no symbols");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the adaptive morse key decoder: key events in, decoded text results out.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 85;
	localparam int DRAIN_CYCLES = 4;
	localparam int END_WAIT_CYCLES = 5000;
	localparam amkd_pkg::result_t NO_RESULT =
		'{amkd_pkg::KIND_LETTER, amkd_pkg::CHAR_NONE, 1'b0};

	// Running state of the keyer, mirrored from the block
	typedef struct {
		bit          key_down;
		logic [31:0] press_at;
		logic [31:0] release_at;
		bit          pending;
		logic [7:0]  sym_bits;
		logic [3:0]  sym_count;
		logic [15:0] est_q6;
		bit          space_ok;
		bit          dash_in_letter;
	} keyer_t;

	// One step of the opening script; typed rows carry their results
	typedef struct {
		amkd_pkg::cmd_t    op;
		logic [31:0]       stamp;
		bit                typed;
		int                count;
		amkd_pkg::result_t first;
		amkd_pkg::result_t second;
	} script_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  cmd = amkd_pkg::CMD_PRESS;
	logic [31:0] time_ms = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [6:0]  char_code;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = amkd_pkg::CFG_UNIT_AT_RESET;
	logic [9:0]  cfg_data = '0;

	keyer_t            keyer;
	logic [9:0]        cfg_floor = amkd_pkg::UNIT_FLOOR_DEFAULT;
	logic [9:0]        cfg_ceiling = amkd_pkg::UNIT_CEILING_DEFAULT;
	amkd_pkg::result_t keyer_out[$];
	amkd_pkg::result_t awaited_results[$];
	logic [6:0]        glyph_of [1:5][0:31];
	logic [31:0]       now_ms;
	bit                quiet = 1'b0;
	int                mismatches = 0;
	int                sent_items = 0;
	int                noise_items = 0;

	string morse_code [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----."
	};

	script_row_t script [23] = '{
		'{amkd_pkg::CMD_POLL,    32'd1000,       1'b1, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_RELEASE, 32'd1010,       1'b1, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_PRESS,   32'd1100,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_RELEASE, 32'd1220,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'd1300,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'd1580,       1'b1, 1,
			'{amkd_pkg::KIND_LETTER, 7'h45, 1'b1}, NO_RESULT},
		'{amkd_pkg::CMD_PRESS,   32'd1600,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_RELEASE, 32'd1960,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'd2800,       1'b1, 2,
			'{amkd_pkg::KIND_LETTER, 7'h54, 1'b0},
			'{amkd_pkg::KIND_SPACE, amkd_pkg::CHAR_SPACE, 1'b1}},
		'{amkd_pkg::CMD_POLL,    32'd5000,       1'b1, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_PRESS,   32'd6000,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_PRESS,   32'd6500,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'd6600,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_RELEASE, 32'd6620,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_PRESS,   32'd6700,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_CANCEL,  32'd6800,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'd6980,       1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_PRESS,   32'hFFFF_FF80,  1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_RELEASE, 32'h0000_0028,  1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'hFFFF_FFFF,  1'b1, 2,
			'{amkd_pkg::KIND_LETTER, 7'h45, 1'b0},
			'{amkd_pkg::KIND_SPACE, amkd_pkg::CHAR_SPACE, 1'b1}},
		'{amkd_pkg::CMD_PRESS,   32'h0000_0000,  1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_RELEASE, 32'hFFFF_FFFF,  1'b0, 0, NO_RESULT, NO_RESULT},
		'{amkd_pkg::CMD_POLL,    32'h0000_07CF,  1'b0, 0, NO_RESULT, NO_RESULT}
	};

	// Register settings per phase; the last phase is drawn at random
	logic [9:0] phase_unit    [PHASES] = '{10'd60, 10'd600, 10'd200, 10'd120, 10'd400, 10'd0};
	logic [9:0] phase_floor   [PHASES] = '{10'd1, 10'd60, 10'd300, 10'd1023, 10'd60, 10'd0};
	logic [9:0] phase_ceiling [PHASES] = '{10'd1023, 10'd600, 10'd100, 10'd1023, 10'd1, 10'd0};

	adaptive_morse_key_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.time_ms      (time_ms),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.char_code    (char_code),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// Fill the symbol-pattern lookup from the dot/dash spellings
	function automatic void build_glyphs();
		logic [4:0] pattern;
		int i;
		int j;
		for (i = 1; i <= 5; i++) begin
			for (j = 0; j < 32; j++) begin
				glyph_of[i][j] = amkd_pkg::CHAR_NONE;
			end
		end
		for (i = 0; i < 36; i++) begin
			pattern = '0;
			for (j = 0; j < morse_code[i].len(); j++) begin
				pattern = {pattern[3:0], morse_code[i][j] == "-"};
			end
			glyph_of[morse_code[i].len()][pattern] = (i < 26) ? 7'(65 + i) : 7'(48 + i - 26);
		end
	endfunction

	function automatic logic [6:0] letter_for(input logic [3:0] count, input logic [7:0] bits);
		logic [7:0] mask;
		mask = (8'd1 << count) - 8'd1;
		if (count == 4'd0 || count > 4'd5) begin
			return amkd_pkg::CHAR_NONE;
		end
		return glyph_of[count][5'(bits & mask)];
	endfunction

	function automatic void drop_letter();
		keyer.sym_bits = '0;
		keyer.sym_count = '0;
		keyer.dash_in_letter = 1'b0;
		keyer.pending = 1'b0;
	endfunction

	// Apply one key event to the keyer and collect the results it gives
	function automatic void advance_keyer(input amkd_pkg::cmd_t op, input logic [31:0] now);
		logic [63:0] span_q6;
		logic [63:0] obs_q6;
		logic [63:0] next_q6;
		logic [63:0] est64;
		logic [63:0] lo_q6;
		logic [63:0] hi_q6;
		logic [6:0]  ch;
		bit          is_dash;
		bit          word_gap;
		keyer_out.delete();
		est64 = {48'd0, keyer.est_q6};
		case (op)
			amkd_pkg::CMD_PRESS: begin
				keyer.key_down = 1'b1;
				keyer.press_at = now;
			end
			amkd_pkg::CMD_CANCEL: begin
				keyer.key_down = 1'b0;
			end
			amkd_pkg::CMD_RELEASE: begin
				if (keyer.key_down) begin
					keyer.key_down = 1'b0;
					span_q6 = {26'd0, now - keyer.press_at, 6'd0};
					is_dash = span_q6 >= est64 * 2;
					keyer.sym_bits = {keyer.sym_bits[6:0], is_dash};
					if (keyer.sym_count != 4'd15) begin
						keyer.sym_count = keyer.sym_count + 4'd1;
					end
					if (is_dash) begin
						keyer.dash_in_letter = 1'b1;
					end
					keyer.pending = 1'b1;
					keyer.release_at = now;
					// a dash counts as a third of its length
					obs_q6 = is_dash ? (span_q6 + 64'd1) / 3 : span_q6;
					next_q6 = (est64 * 3 + obs_q6 + 64'd2) >> 2;
					lo_q6 = {48'd0, cfg_floor, 6'd0};
					hi_q6 = {48'd0, cfg_ceiling, 6'd0};
					if (next_q6 > hi_q6) begin
						next_q6 = hi_q6;
					end
					if (next_q6 < lo_q6) begin
						next_q6 = lo_q6;
					end
					keyer.est_q6 = next_q6[15:0];
					// a long run of dots erases the last word
					if (keyer.sym_count >= amkd_pkg::ERROR_DOT_COUNT &&
						!keyer.dash_in_letter) begin
						drop_letter();
						keyer.space_ok = 1'b0;
						keyer_out.push_back('{amkd_pkg::KIND_DELETE, amkd_pkg::CHAR_NONE, 1'b0});
					end
				end
			end
			default: begin
				if (!keyer.key_down && keyer.pending) begin
					span_q6 = {26'd0, now - keyer.release_at, 6'd0};
					if (span_q6 >= est64 * 3) begin
						word_gap = span_q6 >= est64 * 7;
						ch = letter_for(keyer.sym_count, keyer.sym_bits);
						drop_letter();
						if (ch != amkd_pkg::CHAR_NONE) begin
							keyer_out.push_back('{amkd_pkg::KIND_LETTER, ch, 1'b0});
							keyer.space_ok = 1'b1;
						end
						if (word_gap && keyer.space_ok) begin
							keyer_out.push_back('{amkd_pkg::KIND_SPACE, amkd_pkg::CHAR_SPACE,
								1'b0});
							keyer.space_ok = 1'b0;
						end
					end
				end
			end
		endcase
		if (keyer_out.size() > 0) begin
			keyer_out[keyer_out.size() - 1].last_of_run = 1'b1;
		end
	endfunction

	// Offer one event, hold it until taken, then predict its results
	task automatic send_event(input amkd_pkg::cmd_t op, input logic [31:0] stamp,
		input bit modeled);
		while (!quiet && $urandom_range(0, 99) < 28) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		cmd <= op;
		time_ms <= stamp;
		do @(posedge clk); while (item_stall);
		advance_keyer(op, stamp);
		if (modeled) begin
			foreach (keyer_out[i]) awaited_results.push_back(keyer_out[i]);
		end
		sent_items++;
		@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			amkd_pkg::CFG_UNIT_AT_RESET: begin
				keyer.est_q6 = {value, 6'd0};
			end
			amkd_pkg::CFG_UNIT_FLOOR: cfg_floor = value;
			default: cfg_ceiling = value;
		endcase
		@(negedge clk);
	endtask

	// Wait out every pending result and any event still in flight
	task automatic drain();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One keyed symbol: gap, press, hold for a dot or a dash, release
	task automatic send_symbol(input bit dash);
		int unsigned est;
		int unsigned lo;
		int unsigned hi;
		est = keyer.est_q6;
		now_ms = now_ms + $urandom_range(est >> 7, est >> 5);
		// broken press: drop it and key again
		if ($urandom_range(0, 99) < 4) begin
			send_event(amkd_pkg::CMD_PRESS, now_ms, 1'b1);
			now_ms = now_ms + $urandom_range(0, est >> 6);
			send_event(amkd_pkg::CMD_CANCEL, now_ms, 1'b1);
		end
		send_event(amkd_pkg::CMD_PRESS, now_ms, 1'b1);
		if ($urandom_range(0, 99) < 8) begin
			send_event(amkd_pkg::CMD_POLL, now_ms + $urandom_range(0, est >> 7), 1'b1);
		end
		if ($urandom_range(0, 99) < 5) begin
			now_ms = now_ms + $urandom_range(0, est >> 7);
			send_event(amkd_pkg::CMD_PRESS, now_ms, 1'b1);
		end
		if (dash) begin
			lo = (2 * est + 63) >> 6;
			hi = lo + (est >> 5);
		end else begin
			lo = est >> 7;
			hi = (2 * est - 1) >> 6;
		end
		now_ms = now_ms + $urandom_range(lo, hi);
		send_event(amkd_pkg::CMD_RELEASE, now_ms, 1'b1);
	endtask

	// Close the letter with a poll after a letter or word gap
	task automatic close_letter(input bit word);
		int unsigned est;
		int unsigned letter_lo;
		int unsigned letter_hi;
		int unsigned word_lo;
		logic [31:0] gap;
		est = keyer.est_q6;
		letter_lo = (3 * est + 63) >> 6;
		letter_hi = (7 * est - 1) >> 6;
		word_lo = (7 * est + 63) >> 6;
		// poll just short of the letter gap: nothing yet
		if ($urandom_range(0, 4) == 0) begin
			send_event(amkd_pkg::CMD_POLL, keyer.release_at + letter_lo - 1, 1'b1);
		end
		if (word) begin
			gap = ($urandom_range(0, 3) == 0) ? word_lo :
				$urandom_range(word_lo, word_lo + (est >> 5));
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? letter_lo : $urandom_range(letter_lo, letter_hi);
		end
		now_ms = keyer.release_at + gap;
		send_event(amkd_pkg::CMD_POLL, now_ms, 1'b1);
	endtask

	task automatic send_letter();
		string spelling;
		logic [4:0] bits;
		int unsigned len;
		int j;
		if ($urandom_range(0, 9) == 0) begin
			// arbitrary pattern, often not in the table
			len = $urandom_range(4, 5);
			bits = 5'($urandom());
			for (j = len - 1; j >= 0; j--) begin
				send_symbol(bits[j]);
			end
		end else begin
			spelling = morse_code[$urandom_range(0, 35)];
			for (j = 0; j < spelling.len(); j++) begin
				send_symbol(spelling[j] == "-");
			end
		end
		close_letter($urandom_range(0, 2) == 0);
	endtask

	task automatic send_dot_run();
		int unsigned n;
		n = $urandom_range(8, 10);
		repeat (n) send_symbol(1'b0);
		close_letter($urandom_range(0, 1) == 0);
	endtask

	// Overlong letter: a dash first, then eight to sixteen random symbols, too many for the table
	task automatic send_long_letter();
		int unsigned n;
		n = $urandom_range(8, 16);
		send_symbol(1'b1);
		repeat (n) send_symbol($urandom_range(0, 1) == 1);
		close_letter($urandom_range(0, 1) == 0);
	endtask

	task automatic send_noise();
		amkd_pkg::cmd_t op;
		logic [31:0] stamp;
		op = amkd_pkg::cmd_t'($urandom_range(0, 3));
		if ($urandom_range(0, 1) == 1) begin
			stamp = $urandom();
		end else begin
			stamp = now_ms + $urandom_range(0, keyer.est_q6 >> 4);
		end
		now_ms = stamp;
		noise_items++;
		send_event(op, stamp, 1'b1);
	endtask

	// Receiver stalls at random except during the quiet phase
	initial begin
		forever begin
			@(negedge clk);
			result_stall <= !quiet && ($urandom_range(0, 99) < 28);
		end
	end

	// Check each delivered result against the oldest prediction
	always @(posedge clk) begin : check_results
		amkd_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("unexpected result, char_code", int'(char_code), 0);
			end else begin
				want = awaited_results.pop_front();
				if (kind !== want.kind) begin
					flag_mismatch("kind", int'(kind), int'(want.kind));
				end
				if (char_code !== want.char_code) begin
					flag_mismatch("char_code", int'(char_code), int'(want.char_code));
				end
				if (last_of_run !== want.last_of_run) begin
					flag_mismatch("last_of_run", int'(last_of_run), int'(want.last_of_run));
				end
			end
		end
	end

	initial begin : stimulus
		int p;
		int r;
		int phase_base;
		int unsigned pick;
		build_glyphs();
		keyer = '{default: '0};
		keyer.est_q6 = {amkd_pkg::UNIT_AT_RESET_DEFAULT, 6'd0};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the opening script at the reset settings
		for (r = 0; r < 23; r++) begin
			if (script[r].typed) begin
				if (script[r].count > 0) awaited_results.push_back(script[r].first);
				if (script[r].count > 1) awaited_results.push_back(script[r].second);
			end
			send_event(script[r].op, script[r].stamp, !script[r].typed);
		end
		drain();

		// Random phases, each under its own register setting
		for (p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				phase_unit[p] = 10'($urandom_range(60, 600));
				phase_floor[p] = 10'($urandom_range(1, 1023));
				phase_ceiling[p] = 10'($urandom_range(1, 1023));
			end
			write_register(amkd_pkg::CFG_UNIT_FLOOR, phase_floor[p]);
			write_register(amkd_pkg::CFG_UNIT_CEILING, phase_ceiling[p]);
			write_register(amkd_pkg::CFG_UNIT_AT_RESET, phase_unit[p]);
			cfg_valid <= 1'b0;
			quiet = (p == 2);
			now_ms = $urandom();
			phase_base = sent_items - noise_items;
			while (sent_items - noise_items - phase_base < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					send_letter();
				end else if (pick < 73) begin
					send_dot_run();
				end else if (pick < 78) begin
					send_long_letter();
				end else begin
					send_noise();
				end
			end
			drain();
			quiet = 1'b0;
		end

		// Give stragglers a bounded time to arrive
		for (r = 0; r < END_WAIT_CYCLES && awaited_results.size() != 0; r++) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0) begin
			flag_mismatch("results never delivered", 0, awaited_results.size());
		end
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
